/* rtl/core/rlmsd_pkg.sv */
// Shared constants, types and codes for the RGB LED matrix scan driver.
`timescale 1ns / 1ps
package rlmsd_pkg;

    localparam int ROWS         = 8;
    localparam int COLUMNS      = 8;
    localparam int DRIVER_CHIPS = 8;

    localparam int PAGE_SIZE   = ROWS * COLUMNS;
    localparam int STORE_DEPTH = 2 * PAGE_SIZE;
    localparam int OFF_W       = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CHIP_W      = (DRIVER_CHIPS > 1) ? $clog2(DRIVER_CHIPS) : 1;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_GAMMA_RED   = 2'd0;
    localparam logic [1:0] REG_GAMMA_GREEN = 2'd1;
    localparam logic [1:0] REG_GAMMA_BLUE  = 2'd2;

    localparam logic [5:0] GAMMA_RED_RESET   = 6'd10;
    localparam logic [5:0] GAMMA_GREEN_RESET = 6'd63;
    localparam logic [5:0] GAMMA_BLUE_RESET  = 6'd63;

    localparam logic [3:0] WORD_BITS_PIXEL = 4'd8;
    localparam logic [3:0] WORD_BITS_GAMMA = 4'd6;

    // Channel order within one column (scan) or one chip (gamma)
    localparam logic [1:0] CH_FIRST  = 2'd0;
    localparam logic [1:0] CH_SECOND = 2'd1;
    localparam logic [1:0] CH_LAST   = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SWAP  = 2'd1,
        OP_SCAN  = 2'd2,
        OP_GAMMA = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             row_ok;
        logic             cell_ok;
        logic [2:0]       row;
        logic [OFF_W-1:0] row_base;
        logic [OFF_W-1:0] offset;
        logic [23:0]      pixel;
    } cmd_t;

    typedef struct packed {
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
    } gamma_t;

    typedef struct packed {
        logic [7:0] shift_word;
        logic [3:0] word_bits;
        logic       select_line;
        logic       latch_pulse;
        logic [7:0] row_enable;
        logic       last_word;
    } result_t;

endpackage

/* rtl/core/rlmsd_front.sv */
// Request intake: decodes each request and holds it in a two-entry command queue.
`timescale 1ns / 1ps
module rlmsd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        opcode,
    input  logic [2:0]        row_index,
    input  logic [2:0]        column_index,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    output logic              cmd_valid,
    output rlmsd_pkg::cmd_t   cmd,
    input  logic              cmd_pop
);
    import rlmsd_pkg::*;

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cmd_t       decoded;
    logic       push_fire;
    logic       pop_fire;

    always_comb
    begin
        decoded.op       = op_t'(opcode);
        decoded.row      = row_index;
        decoded.row_ok   = ({29'd0, row_index} < 32'(ROWS));
        decoded.cell_ok  = decoded.row_ok && ({29'd0, column_index} < 32'(COLUMNS));
        decoded.row_base = OFF_W'(32'(row_index) * COLUMNS);
        decoded.offset   = OFF_W'(decoded.row_base + OFF_W'(column_index));
        decoded.pixel    = {red, green, blue};
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push_fire = push && !full;
    assign pop_fire  = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

/* rtl/core/rlmsd_back.sv */
// Command execution: frame store, page swap, scan and gamma sequencer, result queue.
`timescale 1ns / 1ps
module rlmsd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  rlmsd_pkg::cmd_t     cmd,
    output logic                cmd_pop,
    input  rlmsd_pkg::gamma_t   gamma,
    output logic                empty,
    input  logic                pop,
    output rlmsd_pkg::result_t  result
);
    import rlmsd_pkg::*;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GAMMA
    } state_t;

    typedef struct packed {
        logic       is_gamma;
        logic [1:0] ch;
        logic       ok;
        logic       latch;
        logic [7:0] row_enable;
        logic       last;
    } stage_t;

    state_t           state_reg;
    logic             front_page_reg;
    logic [COL_W-1:0] col_reg;
    logic [CHIP_W-1:0] chip_reg;
    logic [1:0]       ch_reg;
    logic             scan_ok_reg;
    logic [2:0]       row_reg;
    logic [OFF_W-1:0] row_base_reg;

    logic [23:0]            store_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] written_reg;
    logic [23:0]            rd_data_reg;
    logic                   rd_written_reg;

    logic   s2_valid_reg;
    stage_t s2_reg;
    stage_t s1_info;

    result_t              out_q [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_reg;
    logic [OUT_PTR_W-1:0] out_rd_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;
    logic [OUT_CNT_W-1:0] out_cnt_next;

    logic              room;
    logic              fire;
    logic              scan_last;
    logic              gamma_last;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] front_base;
    logic [ADDR_W-1:0] back_base;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [5:0]        gamma_level;
    result_t           s2_result;
    logic              out_pop_fire;

    assign room = (32'(out_cnt_reg) + 32'(s2_valid_reg)) < OUT_DEPTH;
    assign fire = (state_reg != S_IDLE) && room;

    assign scan_last  = (32'(col_reg) == COLUMNS - 1) && (ch_reg == CH_LAST);
    assign gamma_last = (32'(chip_reg) == DRIVER_CHIPS - 1) && (ch_reg == CH_LAST);

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;

    assign front_base = front_page_reg ? ADDR_W'(PAGE_SIZE) : '0;
    assign back_base  = front_page_reg ? '0 : ADDR_W'(PAGE_SIZE);
    assign wr_addr    = ADDR_W'(back_base + ADDR_W'(cmd.offset));
    assign rd_addr    = ADDR_W'(front_base + ADDR_W'(row_base_reg) + ADDR_W'(col_reg));

    assign wr_en = cmd_pop && (cmd.op == OP_WRITE) && cmd.cell_ok;
    assign rd_en = fire && (state_reg == S_SCAN) && (ch_reg == CH_FIRST) && scan_ok_reg;

    always_comb
    begin
        s1_info.is_gamma   = (state_reg == S_GAMMA);
        s1_info.ch         = ch_reg;
        s1_info.ok         = scan_ok_reg;
        s1_info.latch      = (state_reg == S_SCAN) && scan_last;
        s1_info.row_enable = ((state_reg == S_SCAN) && scan_last && scan_ok_reg)
                             ? (8'd1 << row_reg) : 8'd0;
        s1_info.last       = (state_reg == S_SCAN) ? scan_last : gamma_last;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= cmd.pixel;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_page_reg <= 1'b0;
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            col_reg        <= '0;
            chip_reg       <= '0;
            ch_reg         <= CH_FIRST;
            scan_ok_reg    <= 1'b0;
            row_reg        <= 3'd0;
            row_base_reg   <= '0;
            s2_valid_reg   <= 1'b0;
            s2_reg         <= '0;
        end
        else
        begin
            s2_valid_reg <= fire;
            if (fire)
            begin
                s2_reg <= s1_info;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        col_reg      <= '0;
                        chip_reg     <= '0;
                        ch_reg       <= CH_FIRST;
                        scan_ok_reg  <= cmd.row_ok;
                        row_reg      <= cmd.row;
                        row_base_reg <= cmd.row_base;
                        case (cmd.op)
                            OP_WRITE:
                            begin
                                if (cmd.cell_ok)
                                begin
                                    written_reg[wr_addr] <= 1'b1;
                                end
                            end
                            OP_SWAP:  front_page_reg <= ~front_page_reg;
                            OP_SCAN:  state_reg <= S_SCAN;
                            OP_GAMMA: state_reg <= S_GAMMA;
                            default:  state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (fire)
                    begin
                        if (ch_reg == CH_LAST)
                        begin
                            ch_reg  <= CH_FIRST;
                            col_reg <= col_reg + COL_W'(1);
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 2'd1;
                        end
                        if (scan_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_GAMMA:
                begin
                    if (fire)
                    begin
                        if (ch_reg == CH_LAST)
                        begin
                            ch_reg   <= CH_FIRST;
                            chip_reg <= chip_reg + CHIP_W'(1);
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 2'd1;
                        end
                        if (gamma_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Gamma words go blue, green, red; scan words go red, green, blue.
    always_comb
    begin
        case (s2_reg.ch)
            CH_FIRST:  gamma_level = gamma.blue;
            CH_SECOND: gamma_level = gamma.green;
            default:   gamma_level = gamma.red;
        endcase

        s2_result.latch_pulse = s2_reg.latch;
        s2_result.row_enable  = s2_reg.row_enable;
        s2_result.last_word   = s2_reg.last;
        if (s2_reg.is_gamma)
        begin
            s2_result.shift_word  = {gamma_level, 2'b00};
            s2_result.word_bits   = WORD_BITS_GAMMA;
            s2_result.select_line = 1'b0;
        end
        else
        begin
            s2_result.word_bits   = WORD_BITS_PIXEL;
            s2_result.select_line = 1'b1;
            if (!(s2_reg.ok && rd_written_reg))
            begin
                s2_result.shift_word = 8'd0;
            end
            else
            begin
                case (s2_reg.ch)
                    CH_FIRST:  s2_result.shift_word = rd_data_reg[23:16];
                    CH_SECOND: s2_result.shift_word = rd_data_reg[15:8];
                    default:   s2_result.shift_word = rd_data_reg[7:0];
                endcase
            end
        end
    end

    assign empty        = (out_cnt_reg == '0);
    assign result       = out_q[out_rd_reg];
    assign out_pop_fire = pop && !empty;

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (s2_valid_reg && !out_pop_fire)
        begin
            out_cnt_next = out_cnt_reg + OUT_CNT_W'(1);
        end
        else if (out_pop_fire && !s2_valid_reg)
        begin
            out_cnt_next = out_cnt_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
            if (s2_valid_reg)
            begin
                out_wr_reg <= out_wr_reg + OUT_PTR_W'(1);
            end
            if (out_pop_fire)
            begin
                out_rd_reg <= out_rd_reg + OUT_PTR_W'(1);
            end
        end
    end

    // Space is reserved before a word is sequenced, so the write never overflows.
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            out_q[out_wr_reg] <= s2_result;
        end
    end

endmodule

/* rtl/core/rgb_led_matrix_scan_driver_core.sv */
// Top level of the RGB LED matrix scan driver: gamma registers, intake and execution.
// A scan or gamma load sends 24 words at one a cycle while the output queue has room; no
// further request is taken from the queue until its last word is sequenced. A pixel write
// or swap is done as it is taken from the queue; requests queue two deep. Reset (rst_n low,
// asynchronous): queues empty, front page 0, frame store reads as zero via written bits,
// gamma red 10, green 63, blue 63.
`timescale 1ns / 1ps
module rgb_led_matrix_scan_driver_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rlmsd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [rlmsd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [rlmsd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                  pready,
    input  logic                                  push,
    output logic                                  full,
    input  logic [1:0]                            opcode,
    input  logic [2:0]                            row_index,
    input  logic [2:0]                            column_index,
    input  logic [7:0]                            red,
    input  logic [7:0]                            green,
    input  logic [7:0]                            blue,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [7:0]                            shift_word,
    output logic [3:0]                            word_bits,
    output logic                                  select_line,
    output logic                                  latch_pulse,
    output logic [7:0]                            row_enable,
    output logic                                  last_word
);
    import rlmsd_pkg::*;

    gamma_t     gamma_reg;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic       cmd_valid;
    logic       cmd_pop;
    cmd_t       cmd;
    result_t    result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg.red   <= GAMMA_RED_RESET;
            gamma_reg.green <= GAMMA_GREEN_RESET;
            gamma_reg.blue  <= GAMMA_BLUE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAMMA_RED:   gamma_reg.red   <= pwdata[5:0];
                REG_GAMMA_GREEN: gamma_reg.green <= pwdata[5:0];
                REG_GAMMA_BLUE:  gamma_reg.blue  <= pwdata[5:0];
                default:         gamma_reg       <= gamma_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_GAMMA_RED:   prdata = {26'd0, gamma_reg.red};
            REG_GAMMA_GREEN: prdata = {26'd0, gamma_reg.green};
            REG_GAMMA_BLUE:  prdata = {26'd0, gamma_reg.blue};
            default:         prdata = '0;
        endcase
    end

    rlmsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .row_index    (row_index),
        .column_index (column_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    rlmsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .gamma     (gamma_reg),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign shift_word  = result.shift_word;
    assign word_bits   = result.word_bits;
    assign select_line = result.select_line;
    assign latch_pulse = result.latch_pulse;
    assign row_enable  = result.row_enable;
    assign last_word   = result.last_word;

endmodule

/* rtl/core/rlmsd_checker.sv */
// Port-level checks for the scan driver, bound to the top level.
`timescale 1ns / 1ps
module rlmsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] shift_word,
    input logic [3:0] word_bits,
    input logic       select_line,
    input logic       latch_pulse,
    input logic [7:0] row_enable,
    input logic       last_word
);
    import rlmsd_pkg::*;

    // A waiting word that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(shift_word) && $stable(last_word)))
        else $error("result changed while stalled");

    // Latch only closes a pixel row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && latch_pulse) |-> (last_word && select_line))
        else $error("latch pulse outside the end of a row scan");

    // Row drive only with the latch, and at most one row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (row_enable != 8'd0)) |-> (latch_pulse && $onehot(row_enable)))
        else $error("bad row enable");

    // Gamma words are six bits, left aligned, with no row drive.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !select_line) |->
            (word_bits == WORD_BITS_GAMMA && shift_word[1:0] == 2'b00 && !latch_pulse))
        else $error("malformed gamma word");

    // Pixel words are full bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && select_line) |-> (word_bits == WORD_BITS_PIXEL))
        else $error("malformed pixel word");

endmodule

bind rgb_led_matrix_scan_driver_core rlmsd_checker u_rlmsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .shift_word  (shift_word),
    .word_bits   (word_bits),
    .select_line (select_line),
    .latch_pulse (latch_pulse),
    .row_enable  (row_enable),
    .last_word   (last_word)
);

/* verif/scan_word_checker.sv */
// Checker for the LED matrix scan driver: predicts output words and compares them.
`timescale 1ns / 1ps
module scan_word_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rlmsd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rlmsd_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                             pready,
    input  logic                             push,
    input  logic                             full,
    input  logic [1:0]                       opcode,
    input  logic [2:0]                       row_index,
    input  logic [2:0]                       column_index,
    input  logic [7:0]                       red,
    input  logic [7:0]                       green,
    input  logic [7:0]                       blue,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [7:0]                       shift_word,
    input  logic [3:0]                       word_bits,
    input  logic                             select_line,
    input  logic                             latch_pulse,
    input  logic [7:0]                       row_enable,
    input  logic                             last_word,
    output int                               fail_count,
    output int                               pending,
    output int                               requests_seen,
    output int                               words_seen
);
    import rlmsd_pkg::*;

    logic [23:0] pixel_page [2][ROWS][COLUMNS];
    logic        front_sel;
    gamma_t      gamma_now;
    result_t     words_due [$];
    result_t     oldest;

    task automatic predict_scan_words(input op_t op, input logic [2:0] row,
                                      input logic [2:0] col, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b);
        result_t     w;
        logic [23:0] px;
        logic [7:0]  enable;
        logic [5:0]  level;
        logic        final_word;
        case (op)
            OP_WRITE:
            begin
                if (row < ROWS && col < COLUMNS)
                    pixel_page[~front_sel][row][col] = {r, g, b};
            end
            OP_SWAP:
            begin
                front_sel = ~front_sel;
            end
            OP_SCAN:
            begin
                // rows past the matrix give blank data and no row drive
                enable = (row < ROWS && row < 8) ? 8'(1 << row) : 8'd0;
                for (int c = 0; c < COLUMNS; c++)
                begin
                    px = (row < ROWS) ? pixel_page[front_sel][row][c] : 24'd0;
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        final_word = (c == COLUMNS - 1) && (ch == CH_LAST);
                        w.shift_word  = 8'(px >> (16 - 8 * ch));
                        w.word_bits   = WORD_BITS_PIXEL;
                        w.select_line = 1'b1;
                        w.latch_pulse = final_word;
                        w.row_enable  = final_word ? enable : 8'd0;
                        w.last_word   = final_word;
                        words_due.push_back(w);
                    end
                end
            end
            default:
            begin
                // blue, green, red per chip, value left-aligned in the byte
                for (int chip = 0; chip < DRIVER_CHIPS; chip++)
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        level = (ch == CH_FIRST) ? gamma_now.blue :
                                (ch == CH_SECOND) ? gamma_now.green : gamma_now.red;
                        final_word = (chip == DRIVER_CHIPS - 1) && (ch == CH_LAST);
                        w.shift_word  = {level, 2'b00};
                        w.word_bits   = WORD_BITS_GAMMA;
                        w.select_line = 1'b0;
                        w.latch_pulse = 1'b0;
                        w.row_enable  = 8'd0;
                        w.last_word   = final_word;
                        words_due.push_back(w);
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 2; p++)
                for (int r = 0; r < ROWS; r++)
                    for (int c = 0; c < COLUMNS; c++)
                        pixel_page[p][r][c] = 24'd0;
            front_sel       = 1'b0;
            gamma_now.red   = GAMMA_RED_RESET;
            gamma_now.green = GAMMA_GREEN_RESET;
            gamma_now.blue  = GAMMA_BLUE_RESET;
            words_due.delete();
            fail_count      = 0;
            pending         = 0;
            requests_seen   = 0;
            words_seen      = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                words_seen++;
                if (words_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: output word 0x%0h with nothing expected", $time, shift_word);
                end
                else
                begin
                    oldest = words_due.pop_front();
                    check_field("shift_word", oldest.shift_word, shift_word);
                    check_field("word_bits", 8'(oldest.word_bits), 8'(word_bits));
                    check_field("select_line", 8'(oldest.select_line), 8'(select_line));
                    check_field("latch_pulse", 8'(oldest.latch_pulse), 8'(latch_pulse));
                    check_field("row_enable", oldest.row_enable, row_enable);
                    check_field("last_word", 8'(oldest.last_word), 8'(last_word));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_GAMMA_RED:   gamma_now.red   = pwdata[5:0];
                    REG_GAMMA_GREEN: gamma_now.green = pwdata[5:0];
                    REG_GAMMA_BLUE:  gamma_now.blue  = pwdata[5:0];
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                requests_seen++;
                predict_scan_words(op_t'(opcode), row_index, column_index, red, green, blue);
            end
            pending = words_due.size();
        end
    end

endmodule

/* verif/tb.sv */
// Testbench top for the LED matrix scan driver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import rlmsd_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = 4'd12;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    logic [1:0]            opcode;
    logic [2:0]            row_index;
    logic [2:0]            column_index;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  empty;
    logic                  pop;
    logic [7:0]            shift_word;
    logic [3:0]            word_bits;
    logic                  select_line;
    logic                  latch_pulse;
    logic [7:0]            row_enable;
    logic                  last_word;

    int fail_count;
    int pending;
    int requests_seen;
    int words_seen;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    bit hold_toggle;
    bit hold_seen;

    rgb_led_matrix_scan_driver_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .row_index    (row_index),
        .column_index (column_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .empty        (empty),
        .pop          (pop),
        .shift_word   (shift_word),
        .word_bits    (word_bits),
        .select_line  (select_line),
        .latch_pulse  (latch_pulse),
        .row_enable   (row_enable),
        .last_word    (last_word)
    );

    scan_word_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .row_index     (row_index),
        .column_index  (column_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .empty         (empty),
        .pop           (pop),
        .shift_word    (shift_word),
        .word_bits     (word_bits),
        .select_line   (select_line),
        .latch_pulse   (latch_pulse),
        .row_enable    (row_enable),
        .last_word     (last_word),
        .fail_count    (fail_count),
        .pending       (pending),
        .requests_seen (requests_seen),
        .words_seen    (words_seen)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
    initial
    begin
        pop = 1'b0;
        hold_seen = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d words still due",
                     $time, STALL_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(input op_t op, input logic [2:0] row, input logic [2:0] col,
                                input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            opcode <= 2'($urandom);
            {row_index, column_index, red, green, blue} <= 30'($urandom);
            @(negedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        row_index <= row;
        column_index <= col;
        red <= r;
        green <= g;
        blue <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input logic [5:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {26'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_gamma(input logic [5:0] rd, input logic [5:0] gr, input logic [5:0] bl);
        // drop push, then let any trailing write or swap finish before touching registers
        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_register({REG_GAMMA_RED, 2'b00}, rd);
        write_register({REG_GAMMA_GREEN, 2'b00}, gr);
        write_register({REG_GAMMA_BLUE, 2'b00}, bl);
        write_register(ADDR_UNUSED, 6'($urandom));
    endtask

    task automatic random_traffic(input int count);
        int          sent;
        int          fill;
        logic [2:0]  row;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 60)
            begin
                // fill part of a row, flip pages, then scan that row
                row = 3'($urandom);
                fill = $urandom_range(1, 8);
                repeat (fill)
                    send_request(OP_WRITE, ($urandom_range(9) == 0) ? 3'($urandom) : row,
                                 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                send_request(OP_SWAP, 3'($urandom), 3'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
                send_request(OP_SCAN, row, 3'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
                sent += fill + 2;
            end
            else
            begin
                send_request(op_t'($urandom_range(3)), 3'($urandom), 3'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        opcode = '0;
        row_index = '0;
        column_index = '0;
        red = '0;
        green = '0;
        blue = '0;
        hold_toggle = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: corners, extreme values, both pages, gamma at reset values
        send_request(OP_WRITE, 3'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_WRITE, 3'd7, 3'd7, 8'h80, 8'h01, 8'hFE);
        send_request(OP_WRITE, 3'd0, 3'd7, 8'hAA, 8'h55, 8'h0F);
        send_request(OP_WRITE, 3'd7, 3'd0, 8'h01, 8'h80, 8'h7F);
        send_request(OP_SCAN, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        send_request(OP_SWAP, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        send_request(OP_SCAN, 3'd0, 3'd7, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_SCAN, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00);
        send_request(OP_GAMMA, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_WRITE, 3'd3, 3'd4, 8'h12, 8'h34, 8'h56);
        send_request(OP_SWAP, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_SCAN, 3'd3, 3'd0, 8'h00, 8'h00, 8'h00);
        send_request(OP_SWAP, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        send_request(OP_SCAN, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00);
        send_request(OP_SCAN, 3'd5, 3'd0, 8'h00, 8'h00, 8'h00);

        // full gamma, no idling; hold the receiver so the input backs up
        set_gamma(6'd63, 6'd63, 6'd63);
        hold_toggle = ~hold_toggle;
        repeat (12)
            send_request(OP_SCAN, 3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
        random_traffic(85);

        set_gamma(6'd0, 6'd0, 6'd0);
        send_idle_pct = 84;
        random_traffic(85);

        set_gamma(6'($urandom), 6'($urandom), 6'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 84;
        random_traffic(85);

        set_gamma(6'($urandom), 6'($urandom), 6'($urandom));
        send_idle_pct = 25;
        recv_stall_pct = 25;
        random_traffic(40);
        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        random_traffic(45);

        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (writes, swaps, row scans, gamma loads) and checked %0d words,",
                 requests_seen, words_seen);
        $display("across several gamma settings, idle and stall mixes, and a backed-up input.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rlmsd_pkg.sv
rtl/core/rlmsd_front.sv
rtl/core/rlmsd_back.sv
rtl/core/rgb_led_matrix_scan_driver_core.sv
rtl/core/rlmsd_checker.sv
verif/scan_word_checker.sv
verif/tb.sv
